[src/psc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_pkg
// shared constants and command type for the palindromic substring counter
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int MAX_LEN    = 64;
    localparam int LEN_W      = $clog2(MAX_LEN + 1);
    localparam int CHAR_W     = 8;
    localparam int COUNT_W    = 12;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // flag summation walks the flag word a chunk per cycle
    localparam int CHUNK      = 8;
    localparam int SUM_CHUNKS = (MAX_LEN + CHUNK - 1) / CHUNK;
    localparam int SUM_W      = SUM_CHUNKS * CHUNK;
    localparam int CHUNK_W    = (SUM_CHUNKS > 1) ? $clog2(SUM_CHUNKS) : 1;
    localparam int POP_W      = $clog2(CHUNK + 1);

    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 16;

    typedef struct packed {
        logic take;      // beat accepted: update cells, load summation word
        logic sum;       // add one chunk of set flags to the count
        logic out_load;  // capture count and overflow into output register
        logic clear;     // end of string: drop flags, length, count
    } t_cmd;

endpackage

[src/psc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_ctrl
// sequencer: accept a beat, walk the summation chunks, hand over the result
// ----------------------------------------------------------------------------
module psc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tlast,
    output logic          o_s_tready,
    input  logic          i_m_tready,
    output logic          o_m_tvalid,
    output psc_pkg::t_cmd o_cmd
);
    import psc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic [CHUNK_W-1:0]  r_chunk, n_chunk;
    logic                r_last, n_last;
    logic                r_out_valid, n_out_valid;
    logic                out_free;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_chunk     = r_chunk;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.take = 1'b1;
                    n_last     = i_s_tlast;
                    n_chunk    = CHUNK_W'(SUM_CHUNKS - 1);
                    n_state    = ST_SUM;
                end
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                if (r_chunk == '0) begin
                    n_state = r_last ? ST_EMIT : ST_IDLE;
                end else begin
                    n_chunk = r_chunk - 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.clear    = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_chunk     <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chunk     <= n_chunk;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[src/psc_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_dp
// row of character/flag cells, chunked flag summation and output register
// ----------------------------------------------------------------------------
module psc_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  psc_pkg::t_cmd                i_cmd,
    input  logic [psc_pkg::CHAR_W-1:0]   i_char,
    output logic [psc_pkg::COUNT_W-1:0]  o_pal_count,
    output logic                         o_too_long
);
    import psc_pkg::*;

    logic [CHAR_W-1:0]  r_char [MAX_LEN];
    logic [MAX_LEN-1:0] r_flag, n_flag;
    logic [LEN_W-1:0]   r_len;
    logic               r_ovf;
    logic [COUNT_W-1:0] r_count;
    logic [SUM_W-1:0]   r_sum_sr;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_ovf;
    logic               full;
    logic [POP_W-1:0]   pop;
    logic [COUNT_W:0]   count_sum;

    assign full = (r_len == LEN_W'(MAX_LEN));

    // cell i: text from i to the newest byte is a palindrome
    for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
        logic inner;
        if (i < MAX_LEN - 1) begin : g_nb
            assign inner = (r_len == LEN_W'(i + 1)) || r_flag[i + 1];
        end else begin : g_edge
            assign inner = 1'b0;
        end

        always_comb begin
            if (r_len == LEN_W'(i)) begin
                n_flag[i] = 1'b1;
            end else if (r_len > LEN_W'(i)) begin
                n_flag[i] = (r_char[i] == i_char) && inner;
            end else begin
                n_flag[i] = 1'b0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.take && (r_len == LEN_W'(i))) begin
                r_char[i] <= i_char;
            end
        end
    end

    always_comb begin
        pop = '0;
        for (int k = 0; k < CHUNK; k++) begin
            pop = pop + POP_W'(r_sum_sr[k]);
        end
        count_sum = {1'b0, r_count} + (COUNT_W + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag  <= '0;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_flag  <= '0;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_cmd.take) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_flag <= n_flag;
                    r_len  <= r_len + 1'b1;
                end
            end
            if (i_cmd.sum) begin
                r_count <= count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sum_sr <= full ? '0 : SUM_W'(n_flag);
        end else if (i_cmd.sum) begin
            r_sum_sr <= r_sum_sr >> CHUNK;
        end
        if (i_cmd.out_load) begin
            r_out_count <= r_count;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_pal_count = r_out_count;
    assign o_too_long  = r_out_ovf;

endmodule

[src/palindromic_substring_counter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palindromic_substring_counter_core
// counts palindromic substrings of a byte stream, one result per string
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                               | tlast
//  ---------+-----+-------------------------------------+-----------------
//  s (char) | in  | [7:0] char_in                       | last_char
//  m (res)  | out | [11:0] pal_count, [12] too_long     | -
//
//  a beat updates every cell together, then the new flags are summed a
//  chunk of 8 per cycle; the next beat is taken only after the sum
//  the final beat of a string then loads the output register, which
//  also clears the cells for the next string
//  reset is synchronous, active low; no clearing pass is needed
//  a result waiting on a stalled master side holds the next final beat back
// ----------------------------------------------------------------------------
module palindromic_substring_counter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave side: one character per beat
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [psc_pkg::S_DATA_W-1:0]  i_s_tdata,   // [7:0] char_in
    input  logic                          i_s_tlast,   // last_char
    // master side: one count per string
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [psc_pkg::M_DATA_W-1:0]  o_m_tdata    // [11:0] pal_count, [12] too_long
);
    import psc_pkg::*;

    t_cmd               cmd;
    logic [COUNT_W-1:0] pal_count;
    logic               too_long;

    // sequencer owns both handshakes
    psc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (cmd)
    );

    // cells, count and output register
    psc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_char      (i_s_tdata[CHAR_W-1:0]),
        .o_pal_count (pal_count),
        .o_too_long  (too_long)
    );

    // pack result fields from the lowest bit, zero padded to whole bytes
    assign o_m_tdata = {{(M_DATA_W - COUNT_W - 1){1'b0}}, too_long, pal_count};

endmodule
